/* hw/rtl/dpv_pkg.sv */
// ----------------------------------------------------------------------------
// dpv_pkg
// Shared types, status codes and checking functions for the payload validator.
// ----------------------------------------------------------------------------
package dpv_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_VALUE   = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  localparam logic [7:0] MAX_STR_LEN = 8'd254;
  localparam int         HEAD_DEPTH  = 8;

  // classified job handed from the front part to the back part
  typedef struct packed {
    logic [15:0] held_type;
    logic [7:0]  len;
    logic [7:0]  lastb;
    logic        zero_seen;
    logic        utf8_bad;
    logic [63:0] head;
  } job_t;

  // days in month with leap adjustment; month 1..12 assumed
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    begin
      case (month)
        4'd2: d = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
        default: d = 5'd31;
      endcase
      month_len = d;
    end
  endfunction

  // leap rule for 1900..2155; only 1900 and 2100 are century exceptions
  function automatic logic is_leap(input logic [11:0] year);
    begin
      is_leap = (year[1:0] == 2'b00) && (year != 12'd1900) && (year != 12'd2100);
    end
  endfunction

  function automatic logic date_ok(input logic [11:0] year, input logic [7:0] month,
                                   input logic [7:0] day);
    begin
      if (month == 8'd0 || month > 8'd12 || day == 8'd0) date_ok = 1'b0;
      else date_ok = day <= {3'd0, month_len(month[3:0], is_leap(year))};
    end
  endfunction

endpackage

/* hw/rtl/datapoint_payload_validator.sv */
// Status: the job of the last byte is written to the queue at that byte's
// transfer and then loaded into the output register once that register has
// room; other bytes give no result.
// Throughput: one byte per cycle while the two-entry job queue has room, set by
// the per-byte front tracking logic; the queue absorbs output stalls.
// Reset: synchronous active-high rst clears counters, decoder state, queue
// and output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// datapoint_payload_validator
// Top level: front classifier, job queue, and status evaluator.
// ----------------------------------------------------------------------------
module datapoint_payload_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] main_type,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [2:0]  status,
  output logic        out_valid,
  input  logic        out_ready
);
  import dpv_pkg::*;

  job_t f_job;
  job_t q_job;
  logic f_valid;
  logic f_ready;
  logic q_valid;
  logic q_ready;

  dpv_front u_front (
    .clk, .rst, .main_type, .data_byte, .last_byte, .in_valid, .in_ready,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  dpv_queue u_queue (
    .clk, .rst, .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  dpv_back u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .status, .out_valid, .out_ready
  );

endmodule

/* hw/rtl/dpv_front.sv */
// ----------------------------------------------------------------------------
// dpv_front
// Accepts payload bytes, tracks count, head bytes, zero and UTF-8 state, and
// emits one classified job per payload on the last byte.
// ----------------------------------------------------------------------------
module dpv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      main_type,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             in_valid,
  output logic             in_ready,
  output dpv_pkg::job_t    job,
  output logic             job_valid,
  input  logic             job_ready
);
  import dpv_pkg::*;

  logic [7:0]  byte_count;
  logic [15:0] held_type;
  logic [7:0]  head_bytes [HEAD_DEPTH];
  logic        zero_seen;
  logic [1:0]  utf8_pending;
  logic [20:0] utf8_code;
  logic [1:0]  utf8_class;
  logic        utf8_fault;

  logic        xfer;
  logic [15:0] cur_type;
  logic [1:0]  pend_next;
  logic [20:0] code_next;
  logic [1:0]  class_next;
  logic        fault_next;
  logic [20:0] lo;

  // a byte moves only when the job queue has room for a possible job
  assign in_ready = job_ready;
  assign xfer     = in_valid && in_ready;
  assign cur_type = (byte_count == 8'd0) ? main_type : held_type;

  // UTF-8 decoder step
  always_comb begin
    pend_next  = utf8_pending;
    code_next  = utf8_code;
    class_next = utf8_class;
    fault_next = utf8_fault;
    lo         = 21'h0;
    if (utf8_pending == 2'd0) begin
      if (data_byte < 8'h80) begin
      end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
        pend_next = 2'd1; code_next = {16'd0, data_byte[4:0]}; class_next = 2'd0;
      end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
        pend_next = 2'd2; code_next = {17'd0, data_byte[3:0]}; class_next = 2'd1;
      end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
        pend_next = 2'd3; code_next = {18'd0, data_byte[2:0]}; class_next = 2'd2;
      end else begin
        fault_next = 1'b1;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      fault_next = 1'b1;
      pend_next  = 2'd0;
    end else begin
      code_next = {utf8_code[14:0], data_byte[5:0]};
      pend_next = utf8_pending - 2'd1;
      case (utf8_class)
        2'd0:    lo = 21'h80;
        2'd1:    lo = 21'h800;
        default: lo = 21'h10000;
      endcase
      if (pend_next == 2'd0 &&
          (code_next < lo || code_next > 21'h10ffff ||
           (code_next >= 21'hd800 && code_next <= 21'hdfff)))
        fault_next = 1'b1;
    end
  end

  // job contents, formed from the byte in flight
  always_comb begin
    job.held_type = cur_type;
    job.len       = (byte_count < MAX_STR_LEN) ? byte_count + 8'd1 : 8'd255;
    job.lastb     = data_byte;
    job.zero_seen = zero_seen;
    job.utf8_bad  = utf8_fault || (utf8_pending != 2'd0);
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      job.head[i*8 +: 8] = (byte_count == 8'(i)) ? data_byte : head_bytes[i];
    end
  end
  assign job_valid = in_valid && last_byte;

  // payload state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 8'd0;
      held_type    <= 16'd0;
      zero_seen    <= 1'b0;
      utf8_pending <= 2'd0;
      utf8_code    <= 21'd0;
      utf8_class   <= 2'd0;
      utf8_fault   <= 1'b0;
    end else if (xfer) begin
      if (last_byte) begin
        byte_count   <= 8'd0;
        held_type    <= 16'd0;
        zero_seen    <= 1'b0;
        utf8_pending <= 2'd0;
        utf8_code    <= 21'd0;
        utf8_class   <= 2'd0;
        utf8_fault   <= 1'b0;
      end else begin
        held_type    <= cur_type;
        if (data_byte == 8'd0) zero_seen <= 1'b1;
        utf8_pending <= pend_next;
        utf8_code    <= code_next;
        utf8_class   <= class_next;
        utf8_fault   <= fault_next;
        if (byte_count != 8'd255) byte_count <= byte_count + 8'd1;
      end
    end
  end

  // head byte store, no reset
  always_ff @(posedge clk) begin
    if (xfer && byte_count < 8'(HEAD_DEPTH)) head_bytes[byte_count[2:0]] <= data_byte;
  end

endmodule

/* hw/rtl/dpv_queue.sv */
// ----------------------------------------------------------------------------
// dpv_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module dpv_queue (
  input  logic          clk,
  input  logic          rst,
  input  dpv_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output dpv_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import dpv_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_job   = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("fill level lost a push");

endmodule

/* hw/rtl/dpv_back.sv */
// ----------------------------------------------------------------------------
// dpv_back
// Evaluates a classified job into a status and holds it in an output register.
// ----------------------------------------------------------------------------
module dpv_back (
  input  logic          clk,
  input  logic          rst,
  input  dpv_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  output logic [2:0]    status,
  output logic          out_valid,
  input  logic          out_ready
);
  import dpv_pkg::*;

  status_t     res;
  logic [7:0]  h [8];
  logic [7:0]  size;
  logic        supported;
  logic [3:0]  bits;
  logic [4:0]  hr;
  logic [7:0]  fl;
  logic [11:0] year;
  logic        bad;

  always_comb begin
    for (int i = 0; i < 8; i++) h[i] = job.head[i*8 +: 8];
  end

  // size and compact width per type
  always_comb begin
    supported = 1'b1;
    bits      = 4'd0;
    size      = 8'd0;
    case (job.held_type)
      16'd1: begin size = 8'd1; bits = 4'd1; end
      16'd2, 16'd23: begin size = 8'd1; bits = 4'd2; end
      16'd3: begin size = 8'd1; bits = 4'd4; end
      16'd31: begin size = 8'd1; bits = 4'd3; end
      16'd4, 16'd5, 16'd6, 16'd17, 16'd18, 16'd20, 16'd21, 16'd25, 16'd26: size = 8'd1;
      16'd7, 16'd8, 16'd9, 16'd22: size = 8'd2;
      16'd10, 16'd11, 16'd30, 16'd232: size = 8'd3;
      16'd12, 16'd13, 16'd14, 16'd15, 16'd27: size = 8'd4;
      16'd16: size = 8'd14;
      16'd19, 16'd29: size = 8'd8;
      16'd24, 16'd28: size = 8'd0;
      16'd251: size = 8'd6;
      default: supported = 1'b0;
    endcase
  end

  // content checks
  always_comb begin
    res  = ST_OK;
    hr   = h[3][4:0];
    fl   = h[6];
    year = 12'd0;
    bad  = 1'b0;
    if (!supported) res = ST_UNSUPPORTED;
    else if (size == 8'd0 ? job.len > MAX_STR_LEN : job.len != size) res = ST_BAD_LENGTH;
    else if (bits != 4'd0) begin
      if ({1'b0, h[0]} >= (9'd1 << bits)) res = ST_BAD_VALUE;
    end else begin
      case (job.held_type)
        16'd9: if ({h[0], h[1]} == 16'h7fff) res = ST_BAD_VALUE;
        16'd10: if (h[0][4:0] > 5'd23 || h[1] > 8'd59 || h[2] > 8'd59) res = ST_RANGE;
        16'd11: begin
          year = (h[2] >= 8'd90) ? 12'd1900 + {4'd0, h[2]} : 12'd2000 + {4'd0, h[2]};
          if (h[2] > 8'd99 || !date_ok(year, h[1], h[0])) res = ST_BAD_VALUE;
        end
        16'd15: begin
          for (int i = 0; i < 3; i++)
            if (h[i][7:4] > 4'd9 || h[i][3:0] > 4'd9) bad = 1'b1;
          if (bad) res = ST_BAD_VALUE;
        end
        16'd17: if (h[0] > 8'd63) res = ST_BAD_VALUE;
        16'd18: if (h[0][6]) res = ST_BAD_VALUE;
        16'd26: if (h[0][7]) res = ST_BAD_VALUE;
        16'd19: begin
          year = fl[4] ? 12'd2000 : 12'd1900 + {4'd0, h[0]};
          if (h[1][7:4] != 4'd0 || h[2][7:5] != 3'd0 || h[4][7:6] != 2'd0 ||
              h[5][7:6] != 2'd0 || h[7][5:0] != 6'd0) bad = 1'b1;
          if (!fl[3] && !date_ok(year, h[1], h[2])) bad = 1'b1;
          if (!fl[1] && (hr > 5'd24 || h[4] > 8'd59 || h[5] > 8'd59 ||
              (hr == 5'd24 && (h[4] != 8'd0 || h[5] != 8'd0)))) bad = 1'b1;
          if (bad) res = ST_BAD_VALUE;
        end
        16'd24, 16'd28: begin
          if (job.lastb != 8'd0 || job.zero_seen ||
              (job.held_type == 16'd28 && job.utf8_bad)) res = ST_BAD_VALUE;
        end
        16'd251: if (h[4] != 8'd0 || h[5] > 8'd15) res = ST_BAD_VALUE;
        default: res = ST_OK;
      endcase
    end
  end

  // output register
  assign job_ready = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (job_ready) out_valid <= job_valid;
  end
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) status <= res;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives datapoint payloads byte by byte into the payload validator, predicts
// the status of every payload and checks each status transfer against it.
// ----------------------------------------------------------------------------
module testbench;
  import dpv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // scoreboard: tracks payload state and holds predicted statuses
  class status_scoreboard;
    status_t     pending[$];
    int unsigned mismatches;
    int unsigned checked;
    logic [7:0]  count;
    logic [15:0] ptype;
    logic [7:0]  head[8];
    bit          zero_seen;
    int unsigned u_left;
    int unsigned u_code;
    int unsigned u_class;
    bit          u_fault;

    function void clear_payload();
      count = 0;
      ptype = 0;
      zero_seen = 0;
      u_left = 0;
      u_code = 0;
      u_class = 0;
      u_fault = 0;
    endfunction

    function int type_len(int unsigned t, output int unsigned bits);
      bits = 0;
      case (t)
        1: begin bits = 1; return 1; end
        2, 23: begin bits = 2; return 1; end
        3: begin bits = 4; return 1; end
        31: begin bits = 3; return 1; end
        4, 5, 6, 17, 18, 20, 21, 25, 26: return 1;
        7, 8, 9, 22: return 2;
        10, 11, 30, 232: return 3;
        12, 13, 14, 15, 27: return 4;
        16: return 14;
        19, 29: return 8;
        24, 28: return 0;
        251: return 6;
        default: return -1;
      endcase
    endfunction

    function bit valid_date(int unsigned y, int unsigned m, int unsigned d);
      int unsigned days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      bit leap;
      if (m == 0 || m > 12 || d == 0) return 0;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      return d <= days[m-1] + ((m == 2 && leap) ? 1 : 0);
    endfunction

    function void utf8_step(logic [7:0] b);
      int unsigned lo;
      if (u_left == 0) begin
        if (b < 8'h80) return;
        if (b >= 8'hc2 && b <= 8'hdf) begin u_left = 1; u_code = b & 31; u_class = 0; end
        else if (b >= 8'he0 && b <= 8'hef) begin u_left = 2; u_code = b & 15; u_class = 1; end
        else if (b >= 8'hf0 && b <= 8'hf4) begin u_left = 3; u_code = b & 7; u_class = 2; end
        else u_fault = 1;
        return;
      end
      if ((b & 8'hc0) != 8'h80) begin
        u_fault = 1;
        u_left = 0;
        return;
      end
      u_code = ((u_code << 6) | (b & 8'h3f)) & 32'h1fffff;
      u_left--;
      if (u_left == 0) begin
        lo = (u_class == 0) ? 32'h80 : (u_class == 1) ? 32'h800 : 32'h10000;
        if (u_code < lo || u_code > 32'h10ffff || (u_code >= 32'hd800 && u_code <= 32'hdfff))
          u_fault = 1;
      end
    endfunction

    function status_t payload_status(int unsigned len, logic [7:0] lastb);
      int unsigned bits, hr, yr;
      int sz;
      logic [7:0] fl;
      sz = type_len(ptype, bits);
      if (sz < 0) return ST_UNSUPPORTED;
      if (sz == 0) begin
        if (len > 254) return ST_BAD_LENGTH;
      end else if (len != sz) return ST_BAD_LENGTH;
      if (bits != 0) return (head[0] >= (1 << bits)) ? ST_BAD_VALUE : ST_OK;
      case (ptype)
        9: return ({head[0], head[1]} == 16'h7fff) ? ST_BAD_VALUE : ST_OK;
        10: return ((head[0] & 31) > 23 || head[1] > 59 || head[2] > 59) ? ST_RANGE : ST_OK;
        11: begin
          if (head[2] > 99) return ST_BAD_VALUE;
          yr = (head[2] >= 90 ? 1900 : 2000) + head[2];
          return valid_date(yr, head[1], head[0]) ? ST_OK : ST_BAD_VALUE;
        end
        15: begin
          for (int i = 0; i < 3; i++)
            if (head[i][7:4] > 9 || head[i][3:0] > 9) return ST_BAD_VALUE;
          return ST_OK;
        end
        17: return (head[0] > 63) ? ST_BAD_VALUE : ST_OK;
        18: return head[0][6] ? ST_BAD_VALUE : ST_OK;
        26: return head[0][7] ? ST_BAD_VALUE : ST_OK;
        19: begin
          fl = head[6];
          hr = head[3] & 31;
          if ((head[1] & 8'hf0) || (head[2] & 8'he0) || (head[4] & 8'hc0) ||
              (head[5] & 8'hc0)) return ST_BAD_VALUE;
          if (head[7] & 8'h3f) return ST_BAD_VALUE;
          if (!fl[3]) begin
            yr = fl[4] ? 2000 : 1900 + head[0];
            if (!valid_date(yr, head[1], head[2])) return ST_BAD_VALUE;
          end
          if (!fl[1] && (hr > 24 || head[4] > 59 || head[5] > 59 ||
              (hr == 24 && (head[4] != 0 || head[5] != 0)))) return ST_BAD_VALUE;
          return ST_OK;
        end
        24, 28: begin
          if (lastb != 0 || zero_seen) return ST_BAD_VALUE;
          if (ptype == 28 && (u_fault || u_left != 0)) return ST_BAD_VALUE;
          return ST_OK;
        end
        251: return (head[4] != 0 || head[5] > 15) ? ST_BAD_VALUE : ST_OK;
        default: return ST_OK;
      endcase
    endfunction

    function new();
      mismatches = 0;
      checked = 0;
      clear_payload();
    endfunction

    // note one accepted byte transfer
    function void note_byte(logic [15:0] t, logic [7:0] b, logic lst);
      int unsigned len;
      if (count == 0) ptype = t;
      if (count < 8) head[count] = b;
      if (!lst) begin
        if (b == 0) zero_seen = 1;
        utf8_step(b);
        if (count < 255) count++;
        return;
      end
      len = (count < 254) ? count + 1 : 255;
      pending.push_back(payload_status(len, b));
      clear_payload();
    endfunction

    // check one status transfer against the oldest prediction
    function void check_status(logic [2:0] got);
      status_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("status %0d with no payload pending", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status mismatch #%0d: expected %0d, got %0d", checked, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic [15:0] main_type;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  status;
  logic        out_valid;
  logic        out_ready;

  status_scoreboard sb;
  bit          calm;      // no idling on either side
  bit          timed_out;
  int unsigned stall_cycles;
  int unsigned payloads;

  datapoint_payload_validator i_dut (
    .clk(clk), .rst(rst), .main_type(main_type), .data_byte(data_byte),
    .last_byte(last_byte), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .out_valid(out_valid), .out_ready(out_ready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // monitor both channels and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(main_type, data_byte, last_byte);
      if (out_valid && out_ready) sb.check_status(status);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCHDOG_LIMIT) begin
        timed_out = 1;
        $display("watchdog: no transfer for %0d cycles, %0d payloads sent",
                 stall_cycles, payloads);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // receiver stalls about 20 percent unless in a calm stretch
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= calm || ($urandom_range(99) >= 20);
  end

  // one byte transfer; random gap first, then hold valid until accepted
  task automatic send_byte(logic [15:0] t, logic [7:0] b, logic lst);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    main_type <= t;
    data_byte <= b;
    last_byte <= lst;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_payload(logic [15:0] t, logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++)
      send_byte(i == 0 ? t : 16'($urandom), bytes[i], i == bytes.size() - 1);
    payloads++;
  endtask

  function automatic int unsigned pick_type();
    int unsigned types[27] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16,
                               17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 28};
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return $urandom;
    if (r < 6) return $urandom_range(1) ? 27 : ($urandom_range(2) == 0 ? 29 :
                      $urandom_range(1) ? 30 : 31);
    if (r < 9) return $urandom_range(1) ? 232 : 251;
    return types[$urandom_range(26)];
  endfunction

  // build a mostly well-formed payload with random content
  function automatic void build_payload(int unsigned t, ref logic [7:0] q[$]);
    int unsigned bits, n, sel;
    int sz;
    status_scoreboard tmp;
    tmp = new();
    q.delete();
    sz = tmp.type_len(t, bits);
    sel = $urandom_range(99);
    if (sz == 0) begin
      n = (sel < 3) ? $urandom_range(300, 250) : $urandom_range(12, 1);
      for (int i = 0; i < n - 1; i++) begin
        if (t == 28 && $urandom_range(3) == 0) begin
          case ($urandom_range(4))
            0: q.push_back(8'($urandom_range(8'hdf, 8'hc2)));
            1: q.push_back(8'($urandom_range(8'hef, 8'he0)));
            2: q.push_back(8'($urandom_range(8'hf4, 8'hf0)));
            3: q.push_back(8'($urandom_range(8'hbf, 8'h80)));
            default: q.push_back(8'($urandom));
          endcase
        end else if ($urandom_range(19) == 0) q.push_back(8'($urandom));
        else q.push_back(8'($urandom_range(8'h7f, 1)));
      end
      q.push_back($urandom_range(9) == 0 ? 8'($urandom) : 8'h00);
      return;
    end
    if (sz < 0) sz = $urandom_range(8, 1);
    n = (sel < 8) ? $urandom_range(16, 1) : sz;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    if (n != sz || sel > 60) return;
    // shape content toward valid values
    case (t)
      10: begin q[0][4:0] = 5'($urandom_range(23)); q[1] = 8'($urandom_range(59));
                q[2] = 8'($urandom_range(59)); end
      11: begin q[0] = 8'($urandom_range(31)); q[1] = 8'($urandom_range(13));
                q[2] = 8'($urandom_range(99)); end
      15: for (int i = 0; i < 3; i++) q[i] = {4'($urandom_range(9)), 4'($urandom_range(9))};
      19: begin
        q[0] = 8'($urandom); q[1] = 8'($urandom_range(12)); q[2] = 8'($urandom_range(31));
        q[3] = {3'($urandom), 5'($urandom_range(24))};
        q[4] = 8'($urandom_range(59)); q[5] = 8'($urandom_range(59));
        q[6] = 8'($urandom) & 8'h1a; q[7] = 8'($urandom) & 8'hc0;
      end
      251: begin q[4] = 8'h00; q[5] = 8'($urandom_range(15)); end
      default: if (bits != 0) q[0] = 8'($urandom_range((1 << bits) - 1));
    endcase
  endfunction

  task automatic directed_payloads();
    send_payload(16'd1, '{8'h01});
    send_payload(16'd1, '{8'hff});
    send_payload(16'd0, '{8'h00});
    send_payload(16'hffff, '{8'h00, 8'h11});
    send_payload(16'd9, '{8'h7f, 8'hff});
    send_payload(16'd10, '{8'h17, 8'h3b, 8'h3c});
    send_payload(16'd11, '{8'd29, 8'd2, 8'd0});
    send_payload(16'd11, '{8'd29, 8'd2, 8'd99});
    send_payload(16'd15, '{8'h12, 8'h3a, 8'h45, 8'h00});
    send_payload(16'd19, '{8'd0, 8'd2, 8'd29, 8'd24, 8'd0, 8'd0, 8'h10, 8'h00});
    send_payload(16'd19, '{8'd0, 8'd1, 8'd1, 8'd24, 8'd1, 8'd0, 8'h00, 8'h00});
    send_payload(16'd24, '{8'h41, 8'h00, 8'h00});
    send_payload(16'd28, '{8'he2, 8'h82, 8'hac, 8'h00});
    send_payload(16'd28, '{8'he0, 8'h80, 8'h80, 8'h00});
    send_payload(16'd28, '{8'hed, 8'ha0, 8'h80, 8'h00});
    send_payload(16'd28, '{8'hf4, 8'h90, 8'h80, 8'h80, 8'h00});
    send_payload(16'd28, '{8'hc3, 8'h00});
    send_payload(16'd251, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f});
    send_payload(16'd17, '{8'd64});
    send_payload(16'd26, '{8'h80});
  endtask

  initial begin
    logic [7:0] q[$];
    int unsigned sent;
    int unsigned ptype;
    sb = new();
    calm = 0;
    timed_out = 0;
    stall_cycles = 0;
    payloads = 0;
    rst = 1;
    in_valid = 0;
    main_type = 0;
    data_byte = 0;
    last_byte = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed_payloads();
    sent = 0;
    while (sent < 2000 && !timed_out) begin
      calm = (sent >= 800 && sent < 1100);
      ptype = pick_type();
      build_payload(ptype, q);
      send_payload(16'(ptype), q);
      sent += q.size();
    end
    in_valid <= 0;
    calm = 0;

    while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    repeat (10) @(posedge clk);
    if (timed_out) begin
      $display("testbench: done, errors");
      $finish;
    end
    $display("covered %0d payloads, %0d status transfers checked, %0d mismatches",
             payloads, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
